>>> rtl/core/srp_pkg.sv
// Package for the sample ring packetizer: widths, constants, codes and shared types.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package srp_pkg;

   // Log geometry. The index width is fixed by the reader and newest index fields.
   localparam int ADDR_W             = 11;
   localparam int LOG_DEPTH          = 2 ** ADDR_W;

   // Packet limits.
   localparam int CNT_W              = 6;
   localparam int MAX_PACKET_SAMPLES = 63;
   localparam int BYTES_PER_ITEM     = 6;
   localparam int MIN_SPACE          = 12;

   // The reader's room, less the header, is clipped to this before the divide by six.
   localparam int CAP_LIMIT          = BYTES_PER_ITEM * MAX_PACKET_SAMPLES;
   localparam int CLIP_W             = $clog2(CAP_LIMIT + 1);

   // floor(x / 6) == (x * 171) >> 10 for every x up to CAP_LIMIT.
   localparam int RECIP              = 171;
   localparam int RECIP_SHIFT        = 10;

   // Sample period register.
   localparam int PERIOD_W           = 20;
   localparam int DEFAULT_PERIOD     = 1000000 / 1000;

   // Shared unit operand widths: 20 x 12 bits gives a 32-bit product.
   localparam int DATA_W             = 32;
   localparam int MUL_A_W            = 20;
   localparam int MUL_B_W            = 12;

   // Request operation codes.
   localparam logic OP_PUSH          = 1'b0;
   localparam logic OP_READ          = 1'b1;

   typedef enum logic [1:0] {
      ALU_HOLD,
      ALU_MUL,
      ALU_SUB
   } srp_alu_op_type;

   typedef struct packed {
      srp_alu_op_type      op;
      logic [DATA_W-1:0]   a;
      logic [DATA_W-1:0]   b;
   } srp_alu_cmd_type;

   typedef enum logic [1:0] {
      KIND_EMPTY  = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_SAMPLE = 2'd2
   } srp_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_P_MUL,
      ST_P_SUB,
      ST_P_WRITE,
      ST_R_DIFF,
      ST_R_CAP,
      ST_R_CLAMP,
      ST_R_FIRST,
      ST_R_BYTES,
      ST_R_HDR,
      ST_SAMP,
      ST_EMPTY
   } srp_state_type;

   typedef struct packed {
      logic signed [15:0]  x;
      logic signed [15:0]  y;
      logic signed [15:0]  z;
      logic [31:0]         stamp;
   } srp_entry_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
   } srp_rd_type;

   typedef struct packed {
      logic                en;
      srp_entry_type       entry;
   } srp_wr_type;

endpackage

>>> rtl/core/srp_channels.sv
// Channel interfaces of the sample ring packetizer: request, response and register write.
// Each carries valid, ready and its payload; depends on srp_pkg.
`timescale 1ns / 1ps

interface srp_req_if import srp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic signed [15:0]   accel_x;
   logic signed [15:0]   accel_y;
   logic signed [15:0]   accel_z;
   logic [31:0]          burst_time_us;
   logic [7:0]           samples_after;
   logic [ADDR_W-1:0]    reader_index;
   logic [15:0]          space_bytes;

   modport source (
      output valid, operation, accel_x, accel_y, accel_z, burst_time_us,
             samples_after, reader_index, space_bytes,
      input  ready
   );
   modport sink (
      input  valid, operation, accel_x, accel_y, accel_z, burst_time_us,
             samples_after, reader_index, space_bytes,
      output ready
   );
endinterface

interface srp_rsp_if import srp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   logic [15:0]          packet_bytes;
   logic [CNT_W-1:0]     sample_count;
   logic [31:0]          first_time_us;
   logic [ADDR_W-1:0]    newest_index;
   logic signed [15:0]   out_x;
   logic signed [15:0]   out_y;
   logic signed [15:0]   out_z;
   logic                 last;

   modport source (
      output valid, kind, packet_bytes, sample_count, first_time_us, newest_index,
             out_x, out_y, out_z, last,
      input  ready
   );
   modport sink (
      input  valid, kind, packet_bytes, sample_count, first_time_us, newest_index,
             out_x, out_y, out_z, last,
      output ready
   );
endinterface

interface srp_csr_if import srp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PERIOD_W-1:0]  interval_us;

   modport source (output valid, interval_us, input ready);
   modport sink   (input valid, interval_us, output ready);
endinterface

>>> rtl/core/srp_alu.sv
// Shared arithmetic unit: one multiplier and one subtractor behind a result register.
// Depends on srp_pkg; driven by the sequencer in the top level.
`timescale 1ns / 1ps

module srp_alu import srp_pkg::*; (
   input  logic              clock,
   input  srp_alu_cmd_type   cmd,
   output logic [DATA_W-1:0] result
);

   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] acc_in;

   always_comb begin
      unique case (cmd.op)
         ALU_MUL: acc_in = DATA_W'(cmd.a[MUL_A_W-1:0] * cmd.b[MUL_B_W-1:0]);
         ALU_SUB: acc_in = cmd.a - cmd.b;
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign result = acc_ff;

endmodule

>>> rtl/core/srp_store.sv
// Sample log memory with its write pointer and a fill tracker standing in for the reset clear.
// Depends on srp_pkg; written on pushes, read one entry a cycle in readout unless stalled.
`timescale 1ns / 1ps

module srp_store import srp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  srp_wr_type        wr,
   input  srp_rd_type        rd,
   output srp_entry_type     rd_entry,
   output logic [ADDR_W-1:0] wp
);

   srp_entry_type       mem [LOG_DEPTH];
   srp_entry_type       rd_data_ff;
   logic                rd_valid_ff;
   logic                rd_valid_in;
   logic [ADDR_W-1:0]   wp_ff;
   logic [ADDR_W-1:0]   wp_in;
   logic                wrapped_ff;
   logic                wrapped_in;

   // Writes go to index 1, 2, ... after reset, so until the pointer wraps to zero an
   // entry has been written exactly when it lies in 1..wp. Unwritten entries read as zero.
   always_comb begin
      wp_in       = wp_ff;
      wrapped_in  = wrapped_ff;
      if (wr.en) begin
         wp_in = wp_ff + 1'b1;
         if (wp_in == '0) begin
            wrapped_in = 1'b1;
         end
      end
      rd_valid_in = rd_valid_ff;
      if (rd.en) begin
         rd_valid_in = wrapped_ff || ((rd.addr != '0) && (rd.addr <= wp_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         wrapped_ff  <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         wrapped_ff  <= wrapped_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wp_in] <= wr.entry;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;
   assign wp       = wp_ff;

endmodule

>>> rtl/core/sample_ring_packetizer_top.sv
// Top level of the sample ring packetizer: sequencer, output register and period register.
// Depends on srp_pkg, the channel interfaces, srp_alu and srp_store.
`timescale 1ns / 1ps
//
//   channel    direction  payload
//   req_chan   in         operation, accel_x/y/z, burst_time_us, samples_after,
//                         reader_index, space_bytes
//   rsp_chan   out        kind, packet_bytes, sample_count, first_time_us,
//                         newest_index, out_x/y/z, last
//   csr_chan   in         interval_us (always ready)
//
// A push passes the accepting cycle, multiply and subtract in the shared unit, then the
// log write. A request sizes the packet in the difference, cap and clamp states; an empty
// item then comes from the empty state, a header from the first, bytes and header states,
// and samples at one per cycle from the memory read port while the output is not stalled.
// The request channel is ready only while the sequencer is idle; output stalls hold it.
// Reset is synchronous; the log reads as zero without a clearing pass.

module sample_ring_packetizer_top import srp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   srp_req_if.sink   req_chan,
   srp_rsp_if.source rsp_chan,
   srp_csr_if.sink   csr_chan
);

   srp_state_type        state_ff, state_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;

   // Latched request.
   logic signed [15:0]   ax_ff, ay_ff, az_ff;
   logic [31:0]          time_ff;
   logic [7:0]           after_ff;
   logic [ADDR_W-1:0]    rd_idx_ff;
   logic [15:0]          space_ff;

   // Packet bookkeeping.
   logic [ADDR_W-1:0]    n_raw_ff, n_raw_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // Output register.
   logic                 out_valid_ff, out_valid_in;
   srp_kind_type         out_kind_ff, out_kind_in;
   logic [15:0]          out_bytes_ff, out_bytes_in;
   logic [CNT_W-1:0]     out_count_ff, out_count_in;
   logic [31:0]          out_time_ff, out_time_in;
   logic [ADDR_W-1:0]    out_newest_ff, out_newest_in;
   logic signed [15:0]   out_x_ff, out_x_in;
   logic signed [15:0]   out_y_ff, out_y_in;
   logic signed [15:0]   out_z_ff, out_z_in;
   logic                 out_last_ff, out_last_in;

   srp_alu_cmd_type      alu_cmd;
   logic [DATA_W-1:0]    alu_res;
   srp_wr_type           wr_req;
   srp_rd_type           rd_req;
   srp_entry_type        rd_entry;
   logic [ADDR_W-1:0]    wp;

   logic                 req_fire;
   logic                 slot_free;
   logic [15:0]          space_less;
   logic [CLIP_W-1:0]    clip;
   logic [CNT_W-1:0]     cap;
   logic [CNT_W-1:0]     n_sel;

   srp_alu u_alu (
      .clock  (clock),
      .cmd    (alu_cmd),
      .result (alu_res)
   );

   srp_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr_req),
      .rd       (rd_req),
      .rd_entry (rd_entry),
      .wp       (wp)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign slot_free      = !out_valid_ff || rsp_chan.ready;

   // Room for samples after the header, clipped so the reciprocal multiply stays exact.
   assign space_less = space_ff - 16'(BYTES_PER_ITEM);
   assign clip       = (space_less > 16'(CAP_LIMIT)) ? CLIP_W'(CAP_LIMIT)
                                                      : space_less[CLIP_W-1:0];
   assign cap        = alu_res[RECIP_SHIFT +: CNT_W];

   always_comb begin
      n_sel = (n_raw_ff > ADDR_W'(cap)) ? cap : n_raw_ff[CNT_W-1:0];
      if (n_sel > CNT_W'(MAX_PACKET_SAMPLES)) begin
         n_sel = CNT_W'(MAX_PACKET_SAMPLES);
      end
   end

   always_comb begin
      state_in      = state_ff;
      period_in     = period_ff;
      n_raw_in      = n_raw_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;

      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_kind_in   = out_kind_ff;
      out_bytes_in  = out_bytes_ff;
      out_count_in  = out_count_ff;
      out_time_in   = out_time_ff;
      out_newest_in = out_newest_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_z_in      = out_z_ff;
      out_last_in   = out_last_ff;

      alu_cmd.op    = ALU_HOLD;
      alu_cmd.a     = '0;
      alu_cmd.b     = '0;
      wr_req.en     = 1'b0;
      wr_req.entry  = {ax_ff, ay_ff, az_ff, alu_res};
      rd_req.en     = 1'b0;
      rd_req.addr   = idx_ff + 1'b1;

      if (csr_chan.valid) begin
         period_in = csr_chan.interval_us;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_chan.operation == OP_READ) ? ST_R_DIFF : ST_P_MUL;
            end
         end
         ST_P_MUL: begin
            alu_cmd.op = ALU_MUL;
            alu_cmd.a  = DATA_W'(period_ff);
            alu_cmd.b  = DATA_W'(after_ff);
            state_in   = ST_P_SUB;
         end
         ST_P_SUB: begin
            alu_cmd.op = ALU_SUB;
            alu_cmd.a  = time_ff;
            alu_cmd.b  = alu_res;
            state_in   = ST_P_WRITE;
         end
         ST_P_WRITE: begin
            wr_req.en = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_R_DIFF: begin
            alu_cmd.op = ALU_SUB;
            alu_cmd.a  = DATA_W'(wp);
            alu_cmd.b  = DATA_W'(rd_idx_ff);
            state_in   = ST_R_CAP;
         end
         ST_R_CAP: begin
            n_raw_in   = alu_res[ADDR_W-1:0];
            alu_cmd.op = ALU_MUL;
            alu_cmd.a  = DATA_W'(clip);
            alu_cmd.b  = DATA_W'(RECIP);
            state_in   = ST_R_CLAMP;
         end
         ST_R_CLAMP: begin
            n_in = n_sel;
            if ((n_raw_ff == '0) || (space_ff < 16'(MIN_SPACE))) begin
               state_in = ST_EMPTY;
            end else begin
               state_in = ST_R_FIRST;
            end
         end
         ST_R_FIRST: begin
            // First sample of the packet: wp - n + 1, modulo the log depth.
            alu_cmd.op = ALU_SUB;
            alu_cmd.a  = DATA_W'(wp) + DATA_W'(1);
            alu_cmd.b  = DATA_W'(n_ff);
            state_in   = ST_R_BYTES;
         end
         ST_R_BYTES: begin
            idx_in      = alu_res[ADDR_W-1:0];
            rd_req.en   = 1'b1;
            rd_req.addr = alu_res[ADDR_W-1:0];
            alu_cmd.op  = ALU_MUL;
            alu_cmd.a   = DATA_W'(n_ff) + DATA_W'(1);
            alu_cmd.b   = DATA_W'(BYTES_PER_ITEM);
            state_in    = ST_R_HDR;
         end
         ST_R_HDR: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_HEADER;
               out_bytes_in  = alu_res[15:0];
               out_count_in  = n_ff;
               out_time_in   = rd_entry.stamp;
               out_newest_in = wp;
               out_x_in      = '0;
               out_y_in      = '0;
               out_z_in      = '0;
               out_last_in   = 1'b0;
               cnt_in        = '0;
               state_in      = ST_SAMP;
            end
         end
         ST_SAMP: begin
            // The read data already holds the entry at idx_ff; the next read is issued
            // only when this one moves into the output register.
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_SAMPLE;
               out_bytes_in  = '0;
               out_count_in  = '0;
               out_time_in   = '0;
               out_newest_in = '0;
               out_x_in      = rd_entry.x;
               out_y_in      = rd_entry.y;
               out_z_in      = rd_entry.z;
               out_last_in   = (cnt_ff == (n_ff - 1'b1));
               rd_req.en     = 1'b1;
               idx_in        = idx_ff + 1'b1;
               cnt_in        = cnt_ff + 1'b1;
               if (cnt_ff == (n_ff - 1'b1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMPTY: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_EMPTY;
               out_bytes_in  = '0;
               out_count_in  = '0;
               out_time_in   = '0;
               out_newest_in = '0;
               out_x_in      = '0;
               out_y_in      = '0;
               out_z_in      = '0;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_W'(DEFAULT_PERIOD);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ax_ff     <= req_chan.accel_x;
         ay_ff     <= req_chan.accel_y;
         az_ff     <= req_chan.accel_z;
         time_ff   <= req_chan.burst_time_us;
         after_ff  <= req_chan.samples_after;
         rd_idx_ff <= req_chan.reader_index;
         space_ff  <= req_chan.space_bytes;
      end
      n_raw_ff      <= n_raw_in;
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      out_kind_ff   <= out_kind_in;
      out_bytes_ff  <= out_bytes_in;
      out_count_ff  <= out_count_in;
      out_time_ff   <= out_time_in;
      out_newest_ff <= out_newest_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_z_ff      <= out_z_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_kind_ff;
   assign rsp_chan.packet_bytes  = out_bytes_ff;
   assign rsp_chan.sample_count  = out_count_ff;
   assign rsp_chan.first_time_us = out_time_ff;
   assign rsp_chan.newest_index  = out_newest_ff;
   assign rsp_chan.out_x         = out_x_ff;
   assign rsp_chan.out_y         = out_y_ff;
   assign rsp_chan.out_z         = out_z_ff;
   assign rsp_chan.last          = out_last_ff;

   // The memory port never sees a write and a read in the same cycle.
   assert property (@(posedge clock) disable iff (reset) !(wr_req.en && rd_req.en))
      else $error("log write and read issued together");

   // A packet in readout always has at least one sample left to send.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SAMP) |-> ((n_ff != '0) && (cnt_ff < n_ff)))
      else $error("sample counter outside packet length");

   // Header length agrees with its sample count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == KIND_HEADER)) |->
      (rsp_chan.packet_bytes ==
       16'(BYTES_PER_ITEM) * (16'(rsp_chan.sample_count) + 16'd1)))
      else $error("header byte total does not match sample count");

   // A header never announces more samples than a packet may hold.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == KIND_HEADER)) |->
      ((rsp_chan.sample_count != '0) &&
       (rsp_chan.sample_count <= CNT_W'(MAX_PACKET_SAMPLES))))
      else $error("header sample count out of range");

endmodule
